/* rtl/core/vmf3_pkg.sv */
// Shared types and constants of the 3-D median filter core.
// Holds the controller state type, the command and status bundles and the
// window size table. No dependencies.
package vmf3_pkg;

  localparam int MAX_RADIUS_DEF = 2;
  localparam int MAX_DIM_DEF    = 64;

  localparam int CFG_W    = 7;
  localparam int RADIUS_W = 2;
  localparam int VOX_W    = 8;
  localparam int IDX_W    = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SIZE_X = 2'd1,
    CFG_SIZE_Y = 2'd2,
    CFG_SIZE_Z = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_PASS,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic sel_init;
    logic sweep_start;
    logic pass_end;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic emit;
    logic border;
    logic sweep_done;
    logic last_bit;
    logic out_free;
  } dp_stat_t;

  // Number of voxels in a cubic window of the given radius.
  function automatic int win_count(logic [RADIUS_W-1:0] r);
    int n;
    case (r)
      2'd0:    n = 1;
      2'd1:    n = 27;
      2'd2:    n = 125;
      default: n = 343;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/vmf3_ctrl.sv */
// Controller state machine of the 3-D median filter core.
// Sequences item intake, window sweeps and result delivery; uses vmf3_pkg.
module vmf3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vmf3_pkg::dp_stat_t stat_i,
  output vmf3_pkg::dp_cmd_t  cmd_o
);

  vmf3_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vmf3_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vmf3_pkg::ST_IDLE: begin
        if (in_valid_i && !stat_i.busy) state_d = vmf3_pkg::ST_DECIDE;
      end
      vmf3_pkg::ST_DECIDE: begin
        if (!stat_i.emit) state_d = vmf3_pkg::ST_IDLE;
        else if (stat_i.border) state_d = vmf3_pkg::ST_OUT;
        else state_d = vmf3_pkg::ST_SWEEP;
      end
      vmf3_pkg::ST_SWEEP: begin
        if (stat_i.sweep_done) state_d = vmf3_pkg::ST_PASS;
      end
      vmf3_pkg::ST_PASS: begin
        if (stat_i.last_bit) state_d = vmf3_pkg::ST_OUT;
        else state_d = vmf3_pkg::ST_SWEEP;
      end
      vmf3_pkg::ST_OUT: begin
        if (stat_i.out_free) state_d = vmf3_pkg::ST_IDLE;
      end
      default: state_d = vmf3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      vmf3_pkg::ST_IDLE: begin
        in_stall_o = stat_i.busy;
        cmd_o.take = in_valid_i && !stat_i.busy;
      end
      vmf3_pkg::ST_DECIDE: begin
        cmd_o.sel_init    = stat_i.emit && !stat_i.border;
        cmd_o.sweep_start = stat_i.emit && !stat_i.border;
      end
      vmf3_pkg::ST_PASS: begin
        cmd_o.pass_end    = 1'b1;
        cmd_o.sweep_start = !stat_i.last_bit;
      end
      vmf3_pkg::ST_OUT: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/core/vmf3_dp.sv */
// Datapath of the 3-D median filter core: configuration, position counters,
// plane store, window sweep, bitwise median select and output register.
// Uses vmf3_pkg; driven by vmf3_ctrl.
module vmf3_dp #(
  parameter int MAX_RADIUS = vmf3_pkg::MAX_RADIUS_DEF,
  parameter int MAX_DIM    = vmf3_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vmf3_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [vmf3_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          cmd_i,
  input  logic [vmf3_pkg::VOX_W-1:0]    voxel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vmf3_pkg::VOX_W-1:0]    value_o,
  output logic                          last_o,
  input  vmf3_pkg::dp_cmd_t             cmd_in_i,
  output vmf3_pkg::dp_stat_t            stat_o
);

  localparam int PLANES  = 2 * MAX_RADIUS + 1;
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int CW      = $clog2(MAX_DIM);
  localparam int PS      = MAX_DIM * MAX_DIM;
  localparam int DEPTH   = PLANES * PS;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(PLANES + 1);
  localparam int SUMW    = $clog2(2 * PLANES);
  localparam int WIN_MAX = PLANES * PLANES * PLANES;
  localparam int NW      = $clog2(WIN_MAX + 1);
  localparam int CNTW    = 3 * DW;
  localparam int RSW     = $clog2(2 * MAX_RADIUS + 2);
  localparam int RW      = vmf3_pkg::RADIUS_W;
  localparam int VW      = vmf3_pkg::VOX_W;

  // Configuration registers and derived sizes.
  logic [RW-1:0]                 radius_q;
  logic [vmf3_pkg::CFG_W-1:0]    size_x_q, size_y_q, size_z_q;
  logic [DW-1:0]                 nx_q, ny_q, nz_q;
  logic [RW-1:0]                 r_q;
  logic [2*DW-1:0]               nyz_q;
  logic [DW+RW-1:0]              rnz_q;
  logic [CNTW-1:0]               total_q, lag_q;
  logic [1:0]                    settle_q;

  function automatic logic [DW-1:0] eff_size(logic [vmf3_pkg::CFG_W-1:0] s);
    logic [DW-1:0] e;
    if (s == '0) e = DW'(1);
    else if (int'(s) > MAX_DIM) e = DW'(MAX_DIM);
    else e = DW'(s);
    return e;
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [SW-1:0] slot, logic [CW-1:0] y,
                                            logic [CW-1:0] z);
    return AW'(slot) * AW'(PS) + AW'(y) * AW'(MAX_DIM) + AW'(z);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RW'(1);
      size_x_q <= vmf3_pkg::CFG_W'(64);
      size_y_q <= vmf3_pkg::CFG_W'(64);
      size_z_q <= vmf3_pkg::CFG_W'(64);
      settle_q <= 2'd3;
    end else begin
      if (cfg_we_i) begin
        settle_q <= 2'd3;
        case (vmf3_pkg::cfg_idx_e'(cfg_idx_i))
          vmf3_pkg::CFG_RADIUS: radius_q <= cfg_data_i[RW-1:0];
          vmf3_pkg::CFG_SIZE_X: size_x_q <= cfg_data_i;
          vmf3_pkg::CFG_SIZE_Y: size_y_q <= cfg_data_i;
          vmf3_pkg::CFG_SIZE_Z: size_z_q <= cfg_data_i;
          default: radius_q <= radius_q;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // Derived sizes settle after a write: clamped sizes, then their products.
  always_ff @(posedge clk_i) begin
    nx_q    <= eff_size(size_x_q);
    ny_q    <= eff_size(size_y_q);
    nz_q    <= eff_size(size_z_q);
    r_q     <= (int'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_q;
    nyz_q   <= (2*DW)'(ny_q) * (2*DW)'(nz_q);
    rnz_q   <= (DW+RW)'(r_q) * (DW+RW)'(nz_q);
    total_q <= CNTW'(nx_q) * CNTW'(nyz_q);
    lag_q   <= CNTW'(r_q) * CNTW'(nyz_q) + CNTW'(rnz_q) + CNTW'(r_q);
  end

  // Input and output positions.
  logic [DW-1:0]   iy_q, iz_q, ox_q, oy_q, oz_q;
  logic [SW-1:0]   islot_q, oslot_q;
  logic [CNTW-1:0] in_cnt_q, out_cnt_q;
  logic            cmd_q, wrote_q, wr_ok, out_end;

  assign wr_ok   = !cmd_i && (in_cnt_q < total_q);
  assign out_end = (out_cnt_q + CNTW'(1)) == total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iy_q <= '0; iz_q <= '0; islot_q <= '0; in_cnt_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0; oslot_q <= '0; out_cnt_q <= '0;
      cmd_q <= 1'b0; wrote_q <= 1'b0;
    end else if (cfg_we_i || (cmd_in_i.out_load && out_end)) begin
      iy_q <= '0; iz_q <= '0; islot_q <= '0; in_cnt_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0; oslot_q <= '0; out_cnt_q <= '0;
    end else begin
      if (cmd_in_i.take) begin
        cmd_q   <= cmd_i;
        wrote_q <= wr_ok;
        if (wr_ok) begin
          in_cnt_q <= in_cnt_q + CNTW'(1);
          if (iz_q + DW'(1) == nz_q) begin
            iz_q <= '0;
            if (iy_q + DW'(1) == ny_q) begin
              iy_q    <= '0;
              islot_q <= (islot_q == SW'(PLANES - 1)) ? '0 : islot_q + SW'(1);
            end else begin
              iy_q <= iy_q + DW'(1);
            end
          end else begin
            iz_q <= iz_q + DW'(1);
          end
        end
      end
      if (cmd_in_i.out_load) begin
        out_cnt_q <= out_cnt_q + CNTW'(1);
        if (oz_q + DW'(1) == nz_q) begin
          oz_q <= '0;
          if (oy_q + DW'(1) == ny_q) begin
            oy_q    <= '0;
            ox_q    <= ox_q + DW'(1);
            oslot_q <= (oslot_q == SW'(PLANES - 1)) ? '0 : oslot_q + SW'(1);
          end else begin
            oy_q <= oy_q + DW'(1);
          end
        end else begin
          oz_q <= oz_q + DW'(1);
        end
      end
    end
  end

  logic out_left;
  assign out_left = out_cnt_q < total_q;

  assign stat_o.busy = settle_q != 2'd0;
  assign stat_o.emit = cmd_q ? ((in_cnt_q == total_q) && out_left)
                             : (wrote_q && out_left && (in_cnt_q > out_cnt_q + lag_q));

  logic [DW:0] rx;
  assign rx = (DW+1)'(r_q);
  assign stat_o.border = !((ox_q >= r_q) && (oy_q >= r_q) && (oz_q >= r_q) &&
                           ((DW+1)'(ox_q) + rx < (DW+1)'(nx_q)) &&
                           ((DW+1)'(oy_q) + rx < (DW+1)'(ny_q)) &&
                           ((DW+1)'(oz_q) + rx < (DW+1)'(nz_q)));

  // Window sweep: one store read per cycle, plane, then row, then column.
  logic [RSW-1:0]  wa_q, wb_q, wc_q, two_r;
  logic [SW-1:0]   ws_q, s0;
  logic [SUMW-1:0] ssum;
  logic            issuing_q, is_last, rd_vld_q, rlast_q, done_q;
  logic [DW:0]     wy, wz;
  logic [AW-1:0]   raddr, waddr;
  logic [VW-1:0]   rdata_q;
  logic [VW-1:0]   mem [DEPTH];

  assign two_r   = RSW'({r_q, 1'b0});
  assign ssum    = SUMW'(oslot_q) + SUMW'(PLANES) - SUMW'(r_q);
  assign s0      = (ssum >= SUMW'(PLANES)) ? SW'(ssum - SUMW'(PLANES)) : SW'(ssum);
  assign is_last = (wa_q == two_r) && (wb_q == two_r) && (wc_q == two_r);
  assign wy      = (DW+1)'(oy_q) - rx + (DW+1)'(wb_q);
  assign wz      = (DW+1)'(oz_q) - rx + (DW+1)'(wc_q);
  assign raddr   = addr_of(ws_q, wy[CW-1:0], wz[CW-1:0]);
  assign waddr   = addr_of(islot_q, iy_q[CW-1:0], iz_q[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rlast_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      rd_vld_q <= issuing_q;
      rlast_q  <= issuing_q && is_last;
      done_q   <= rd_vld_q && rlast_q;
      if (cmd_in_i.sweep_start) begin
        issuing_q <= 1'b1;
      end else if (issuing_q && is_last) begin
        issuing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.sweep_start) begin
      wa_q <= '0; wb_q <= '0; wc_q <= '0; ws_q <= s0;
    end else if (issuing_q) begin
      if (wc_q == two_r) begin
        wc_q <= '0;
        if (wb_q == two_r) begin
          wb_q <= '0;
          wa_q <= wa_q + RSW'(1);
          ws_q <= (ws_q == SW'(PLANES - 1)) ? '0 : ws_q + SW'(1);
        end else begin
          wb_q <= wb_q + RSW'(1);
        end
      end else begin
        wc_q <= wc_q + RSW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.take && wr_ok) mem[waddr] <= voxel_i;
    rdata_q <= mem[raddr];
  end

  // Median by bitwise rank selection: each sweep settles one bit, MSB first.
  logic [VW-1:0] med_q, mask_q, sel_q;
  logic [NW-1:0] k_q, cnt0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.sel_init) begin
      med_q  <= '0;
      mask_q <= '0;
      sel_q  <= {1'b1, {(VW-1){1'b0}}};
      k_q    <= NW'(vmf3_pkg::win_count(r_q) / 2);
    end else if (cmd_in_i.pass_end) begin
      if (k_q >= cnt0_q) begin
        med_q <= med_q | sel_q;
        k_q   <= k_q - cnt0_q;
      end
      mask_q <= mask_q | sel_q;
      sel_q  <= sel_q >> 1;
    end
    if (cmd_in_i.sweep_start) begin
      cnt0_q <= '0;
    end else if (rd_vld_q && (((rdata_q ^ med_q) & mask_q) == '0) &&
                 ((rdata_q & sel_q) == '0)) begin
      cnt0_q <= cnt0_q + NW'(1);
    end
  end

  assign stat_o.sweep_done = done_q;
  assign stat_o.last_bit   = sel_q[0];

  // Output register.
  logic          ov_q, last_q;
  logic [VW-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_in_i.out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.out_load) begin
      value_q <= stat_o.border ? '0 : med_q;
      last_q  <= out_end;
    end
  end

  assign stat_o.out_free = !ov_q || !out_stall_i;
  assign out_valid_o     = ov_q;
  assign value_o         = value_q;
  assign last_o          = last_q;

endmodule

/* rtl/core/volume_median_filter_3d_core.sv */
// Streaming 3-D median filter over a byte volume with a cubic window of side
// 2r+1. Voxels enter in raster order and are kept in a store of 2*MAX_RADIUS+1
// planes; output position p leaves once input p + r*ny*nz + r*nz + r is in,
// with border positions reported as 0 and the final output flagged by last.
// One item is handled at a time. A voxel item that produces no output goes
// from idle through decide and back to idle; a border output goes from decide
// straight to the output state; an interior output sweeps the whole window
// once per result bit, MSB first, through the single read port of the plane
// store, before the output state. After reset and after each register write
// the input stalls while the derived sizes settle.
module volume_median_filter_3d_core #(
  parameter int MAX_RADIUS = vmf3_pkg::MAX_RADIUS_DEF,
  parameter int MAX_DIM    = vmf3_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vmf3_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [vmf3_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [vmf3_pkg::VOX_W-1:0]  voxel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [vmf3_pkg::VOX_W-1:0]  value_o,
  output logic                        last_o
);

  vmf3_pkg::dp_cmd_t  dp_cmd;
  vmf3_pkg::dp_stat_t dp_stat;

  vmf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  vmf3_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .voxel_i     (voxel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .last_o      (last_o),
    .cmd_in_i    (dp_cmd),
    .stat_o      (dp_stat)
  );

endmodule

/* rtl/core/vmf3_checker.sv */
// Port-level checks of the 3-D median filter core and their bind.
// Sees only the top-level ports; uses vmf3_pkg for widths.
module vmf3_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [vmf3_pkg::VOX_W-1:0]  value_o,
  input logic                        last_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(last_o))
    else $error("result payload changed while stalled");

  // Items are handled one at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second input beat taken before the first was handled");

  // Input is stalled right after a register write, while derived sizes settle.
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken right after a register write");

endmodule

bind volume_median_filter_3d_core vmf3_checker u_vmf3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .last_o      (last_o)
);
